// File: rtl/dfbu_pkg.sv
// ----------------------------------------------------------------------------
// dfbu_pkg
// Shared widths, codes and reset values for the distance-field bilinear
// upscaler and its stream interfaces.
// ----------------------------------------------------------------------------
package dfbu_pkg;

    // Field widths
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned PIX_W    = 12;
    localparam int unsigned COORD_W  = 5;
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned ALPHA_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // Default grid edge
    localparam int unsigned GRID_EDGE_DEF = 32;

    // Output size after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd32;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // Alpha threshold and remap offset
    localparam logic [ALPHA_W-1:0] ALPHA_THRESH = 8'd128;
    localparam logic [9:0]         REMAP_BIAS   = 10'd255;

endpackage

// File: rtl/dfbu_stream_if.sv
// ----------------------------------------------------------------------------
// dfbu stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dfbu_in_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [dfbu_pkg::COORD_W-1:0]    grid_col;
    logic [dfbu_pkg::COORD_W-1:0]    grid_row;
    logic [dfbu_pkg::SAMPLE_W-1:0]   sample_value;
    logic [dfbu_pkg::PIX_W-1:0]      pixel_x;
    logic [dfbu_pkg::PIX_W-1:0]      pixel_y;

    modport source (
        output valid, operation, grid_col, grid_row, sample_value, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, operation, grid_col, grid_row, sample_value, pixel_x, pixel_y,
        output ready
    );
endinterface

interface dfbu_out_if;
    logic                          valid;
    logic                          ready;
    logic [dfbu_pkg::ALPHA_W-1:0]  alpha_out;

    modport source (
        output valid, alpha_out,
        input  ready
    );
    modport sink (
        input  valid, alpha_out,
        output ready
    );
endinterface

// File: rtl/distance_field_bilinear_upscale.sv
// ----------------------------------------------------------------------------
// distance_field_bilinear_upscale
// Bilinear upscaler for a signed-distance-field alpha grid.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries load beats (operation 0: one grid sample, stored with its row
//   flipped) and query beats (operation 1: one output pixel). Loads give no
//   result; each query gives one alpha_out beat on out_ch, in order.
//   cfg_we/cfg_index/cfg_data set out_width (index 0) and out_height (index 1);
//   write them only while no beat is in flight.
// Pipeline and throughput:
//   Nine-stage pipeline; a query accepted on in_ch passes stages 1 to 9 and
//   its result is shown on out_ch from the stage 9 registers. One beat is
//   accepted every cycle while out_ch is not stalled. Throughput is set by
//   the pipeline: four grid reads per query come from four copies of the
//   sample memory, and the final division is split over stages 8 and 9.
// Reset:
//   Clears all stage valid bits and sets both sizes to 32. The sample memory
//   is not cleared; samples must be loaded before they are queried.
// Stall:
//   When out_ch holds a result and ready is low, the whole pipeline holds and
//   in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module distance_field_bilinear_upscale #(
    parameter int unsigned GRID_EDGE = dfbu_pkg::GRID_EDGE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dfbu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfbu_pkg::SIZE_W-1:0]       cfg_data,
    dfbu_in_if.sink                           in_ch,
    dfbu_out_if.source                        out_ch
);
    import dfbu_pkg::*;

    localparam int unsigned IW    = $clog2(GRID_EDGE);
    localparam int unsigned QB    = $clog2(2 * GRID_EDGE);
    localparam int unsigned NB    = $clog2(((1 << SIZE_W) - 1) / GRID_EDGE + 1);
    localparam int unsigned DEPTH = GRID_EDGE * GRID_EDGE;
    localparam int unsigned IDXW  = $clog2(DEPTH);
    localparam int unsigned RK    = SIZE_W + IW;
    localparam int unsigned RM    = ((1 << RK) + GRID_EDGE - 1) / GRID_EDGE;
    localparam int unsigned RMW   = SIZE_W + 2;
    localparam int unsigned PW    = SIZE_W + 1;
    localparam int unsigned SW    = SAMPLE_W + NB;
    localparam int unsigned NUMW  = SAMPLE_W + 2 * NB;
    localparam int unsigned DENW  = 2 * NB;
    localparam logic [RMW-1:0] RECIP = RMW'(RM);
    localparam logic [IW-1:0]  LAST  = IW'(GRID_EDGE - 1);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // size / GRID_EDGE by reciprocal multiply; zero becomes one
    function automatic logic [NB-1:0] cell_step(input logic [SIZE_W-1:0] size);
        logic [SIZE_W+RMW-1:0] prod;
        logic [NB-1:0]         n;
        prod = (SIZE_W+RMW)'(size) * (SIZE_W+RMW)'(RECIP);
        n    = NB'(prod >> RK);
        if (n == '0)
            n = NB'(1);
        return n;
    endfunction

    // restoring division of diff by n, QB quotient bits
    function automatic logic [QB-1:0] axis_quot(input logic [PIX_W-1:0] diff,
                                                input logic [NB-1:0] n);
        logic [NB-1:0] rem;
        logic [NB:0]   trial;
        logic [QB-1:0] q;
        rem = NB'(diff >> QB);
        q   = '0;
        for (int i = QB - 1; i >= 0; i--) begin
            trial = {rem, diff[i]};
            if (trial >= {1'b0, n}) begin
                trial = trial - {1'b0, n};
                q[i]  = 1'b1;
            end
            rem = NB'(trial);
        end
        return q;
    endfunction

    // neighbor indexes {a, b} along one axis
    function automatic logic [2*IW-1:0] axis_index(input logic [PIX_W-1:0] p,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [NB-1:0] n);
        logic [NB-1:0]     h;
        logic [SIZE_W-1:0] lim;
        logic [PIX_W-1:0]  diff;
        logic [QB-1:0]     q;
        logic [QB:0]       q1;
        logic [IW-1:0]     a;
        logic [IW-1:0]     b;
        h    = n >> 1;
        lim  = size - SIZE_W'(h);
        diff = PIX_W'(SIZE_W'(p) - SIZE_W'(h));
        q    = axis_quot(diff, n);
        q1   = (QB+1)'(q) + (QB+1)'(1);
        if (SIZE_W'(p) < SIZE_W'(h)) begin
            a = '0;
            b = '0;
        end else if (SIZE_W'(p) >= lim) begin
            a = LAST;
            b = LAST;
        end else begin
            a = (q > QB'(GRID_EDGE - 1)) ? LAST : IW'(q);
            b = (q1 > (QB+1)'(GRID_EDGE - 1)) ? LAST : IW'(q1);
        end
        return {a, b};
    endfunction

    // weights {w0, w1} along one axis
    function automatic logic [2*NB-1:0] axis_weight(input logic [PIX_W-1:0] p,
                                                    input logic [PW-1:0] pos0,
                                                    input logic [NB-1:0] n);
        logic [PW-1:0] pos1;
        logic [NB-1:0] w0;
        logic [NB-1:0] w1;
        pos1 = pos0 + PW'(n);
        if (PW'(p) < pos0) begin
            w0 = n;
            w1 = '0;
        end else if (PW'(p) > pos1) begin
            w0 = '0;
            w1 = n;
        end else begin
            w1 = NB'(PW'(p) - pos0);
            w0 = n - w1;
        end
        return {w0, w1};
    endfunction

    // four restoring steps of the final division
    function automatic logic [DENW+3:0] div_steps(input logic [DENW-1:0] rem_in,
                                                  input logic [3:0] bits,
                                                  input logic [DENW-1:0] den);
        logic [DENW-1:0] rem;
        logic [DENW:0]   trial;
        logic [3:0]      q;
        rem = rem_in;
        q   = '0;
        for (int i = 3; i >= 0; i--) begin
            trial = {rem, bits[i]};
            if (trial >= {1'b0, den}) begin
                trial = trial - {1'b0, den};
                q[i]  = 1'b1;
            end
            rem = DENW'(trial);
        end
        return {rem, q};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: whole pipe advances unless the output is stalled
    // ------------------------------------------------------------------
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic op1_reg, op2_reg, op3_reg, op4_reg, op5_reg, op6_reg, op7_reg, op8_reg;
    logic op9_reg;

    assign adv         = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    // stage 1: capture beat, cell steps
    logic [COORD_W-1:0]  col1_reg, row1_reg;
    logic [SAMPLE_W-1:0] smp1_reg;
    logic [PIX_W-1:0]    px1_reg, py1_reg;
    logic [SIZE_W-1:0]   sx1_reg, sy1_reg;
    logic [NB-1:0]       nx1_reg, ny1_reg;
    logic [NB-1:0]       nx1_next, ny1_next;
    // stage 2: neighbor indexes
    logic [COORD_W-1:0]  col2_reg, row2_reg;
    logic [SAMPLE_W-1:0] smp2_reg;
    logic [PIX_W-1:0]    px2_reg, py2_reg;
    logic [NB-1:0]       nx2_reg, ny2_reg;
    logic [IW-1:0]       l2_reg, r2_reg, t2_reg, b2_reg;
    logic [2*IW-1:0]     xi2_next, yi2_next;
    // stage 3: sample positions, denominator
    logic [COORD_W-1:0]  col3_reg, row3_reg;
    logic [SAMPLE_W-1:0] smp3_reg;
    logic [PIX_W-1:0]    px3_reg, py3_reg;
    logic [NB-1:0]       nx3_reg, ny3_reg;
    logic [IW-1:0]       l3_reg, r3_reg, t3_reg, b3_reg;
    logic [PW-1:0]       posx3_reg, posy3_reg;
    logic [DENW-1:0]     den3_reg;
    // stage 4: weights and memory addresses
    logic [IDXW-1:0]     ra4_reg [4];
    logic [IDXW-1:0]     wa4_reg;
    logic [SAMPLE_W-1:0] wd4_reg;
    logic                ing4_reg;
    logic [NB-1:0]       wx0_4_reg, wx1_4_reg, wy0_4_reg, wy1_4_reg;
    logic [DENW-1:0]     den4_reg;
    logic [2*NB-1:0]     wx4_next, wy4_next;
    // stage 5: memory read data
    logic [SAMPLE_W-1:0] rd5_reg [4];
    logic [NB-1:0]       wx0_5_reg, wx1_5_reg, wy0_5_reg, wy1_5_reg;
    logic [DENW-1:0]     den5_reg;
    // stage 6: horizontal blends
    logic [SW-1:0]       top6_reg, bot6_reg;
    logic [NB-1:0]       wy0_6_reg, wy1_6_reg;
    logic [DENW-1:0]     den6_reg;
    // stage 7: numerator
    logic [NUMW-1:0]     num7_reg;
    logic [DENW-1:0]     den7_reg;
    // stage 8: upper quotient bits
    logic [DENW-1:0]     rem8_reg;
    logic [3:0]          qhi8_reg;
    logic [3:0]          low8_reg;
    logic [DENW-1:0]     den8_reg;
    logic [DENW+3:0]     div8_next;
    // stage 9: output
    logic [ALPHA_W-1:0]  alpha9_reg;
    logic [DENW+3:0]     div9_next;
    logic [ALPHA_W-1:0]  quot9_next;
    logic [9:0]          remap9_next;
    logic [ALPHA_W-1:0]  alpha9_next;

    // ------------------------------------------------------------------
    // Stage logic
    // ------------------------------------------------------------------
    assign nx1_next = cell_step(width_reg);
    assign ny1_next = cell_step(height_reg);
    assign xi2_next = axis_index(px1_reg, sx1_reg, nx1_reg);
    assign yi2_next = axis_index(py1_reg, sy1_reg, ny1_reg);
    assign wx4_next = axis_weight(px3_reg, posx3_reg, nx3_reg);
    assign wy4_next = axis_weight(py3_reg, posy3_reg, ny3_reg);
    assign div8_next = div_steps(DENW'(num7_reg >> ALPHA_W), num7_reg[7:4], den7_reg);
    assign div9_next = div_steps(rem8_reg, low8_reg, den8_reg);
    assign quot9_next = {qhi8_reg, div9_next[3:0]};

    // threshold and remap
    always_comb
    begin
        remap9_next = (REMAP_BIAS + {1'b0, quot9_next, 1'b0}) >> 2;
        if (quot9_next >= ALPHA_THRESH)
            alpha9_next = ALPHA_W'(remap9_next);
        else
            alpha9_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            op1_reg  <= in_ch.operation;
            col1_reg <= in_ch.grid_col;
            row1_reg <= in_ch.grid_row;
            smp1_reg <= in_ch.sample_value;
            px1_reg  <= in_ch.pixel_x;
            py1_reg  <= in_ch.pixel_y;
            sx1_reg  <= width_reg;
            sy1_reg  <= height_reg;
            nx1_reg  <= nx1_next;
            ny1_reg  <= ny1_next;
            // stage 2
            op2_reg  <= op1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            smp2_reg <= smp1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            {l2_reg, r2_reg} <= xi2_next;
            {t2_reg, b2_reg} <= yi2_next;
            // stage 3
            op3_reg   <= op2_reg;
            col3_reg  <= col2_reg;
            row3_reg  <= row2_reg;
            smp3_reg  <= smp2_reg;
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            nx3_reg   <= nx2_reg;
            ny3_reg   <= ny2_reg;
            l3_reg    <= l2_reg;
            r3_reg    <= r2_reg;
            t3_reg    <= t2_reg;
            b3_reg    <= b2_reg;
            posx3_reg <= PW'(nx2_reg >> 1) + PW'(nx2_reg) * PW'(l2_reg);
            posy3_reg <= PW'(ny2_reg >> 1) + PW'(ny2_reg) * PW'(t2_reg);
            den3_reg  <= DENW'(nx2_reg) * DENW'(ny2_reg);
            // stage 4
            op4_reg    <= op3_reg;
            ra4_reg[0] <= IDXW'(t3_reg) * IDXW'(GRID_EDGE) + IDXW'(l3_reg);
            ra4_reg[1] <= IDXW'(t3_reg) * IDXW'(GRID_EDGE) + IDXW'(r3_reg);
            ra4_reg[2] <= IDXW'(b3_reg) * IDXW'(GRID_EDGE) + IDXW'(l3_reg);
            ra4_reg[3] <= IDXW'(b3_reg) * IDXW'(GRID_EDGE) + IDXW'(r3_reg);
            wa4_reg    <= IDXW'((GRID_EDGE - 1 - 32'(row3_reg)) * GRID_EDGE
                                + 32'(col3_reg));
            wd4_reg    <= smp3_reg;
            ing4_reg   <= (32'(col3_reg) < GRID_EDGE) && (32'(row3_reg) < GRID_EDGE);
            {wx0_4_reg, wx1_4_reg} <= wx4_next;
            {wy0_4_reg, wy1_4_reg} <= wy4_next;
            den4_reg   <= den3_reg;
            // stage 5 (read data is registered in the memory blocks)
            op5_reg   <= op4_reg;
            wx0_5_reg <= wx0_4_reg;
            wx1_5_reg <= wx1_4_reg;
            wy0_5_reg <= wy0_4_reg;
            wy1_5_reg <= wy1_4_reg;
            den5_reg  <= den4_reg;
            // stage 6
            op6_reg   <= op5_reg;
            top6_reg  <= SW'(rd5_reg[0]) * SW'(wx0_5_reg) + SW'(rd5_reg[1]) * SW'(wx1_5_reg);
            bot6_reg  <= SW'(rd5_reg[2]) * SW'(wx0_5_reg) + SW'(rd5_reg[3]) * SW'(wx1_5_reg);
            wy0_6_reg <= wy0_5_reg;
            wy1_6_reg <= wy1_5_reg;
            den6_reg  <= den5_reg;
            // stage 7
            op7_reg  <= op6_reg;
            num7_reg <= NUMW'(top6_reg) * NUMW'(wy0_6_reg)
                      + NUMW'(bot6_reg) * NUMW'(wy1_6_reg);
            den7_reg <= den6_reg;
            // stage 8
            op8_reg  <= op7_reg;
            rem8_reg <= div8_next[DENW+3:4];
            qhi8_reg <= div8_next[3:0];
            low8_reg <= num7_reg[3:0];
            den8_reg <= den7_reg;
            // stage 9
            op9_reg    <= op8_reg;
            alpha9_reg <= alpha9_next;
        end
    end

    // ------------------------------------------------------------------
    // Sample memory: four copies, one read port each, shared write
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 4; k++)
    begin : g_mem
        logic [SAMPLE_W-1:0] mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (v4_reg && op4_reg == OP_LOAD && ing4_reg)
                    mem[wa4_reg] <= wd4_reg;
                rd5_reg[k] <= mem[ra4_reg[k]];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output
    // ------------------------------------------------------------------
    assign out_ch.valid     = v9_reg && op9_reg == OP_QUERY;
    assign out_ch.alpha_out = alpha9_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && op3_reg == OP_QUERY |-> l3_reg <= r3_reg && t3_reg <= b3_reg)
        else $error("neighbor index order broken");

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && op4_reg == OP_QUERY |->
            den4_reg == DENW'((NB+1)'(wx0_4_reg) + (NB+1)'(wx1_4_reg))
                      * DENW'((NB+1)'(wy0_4_reg) + (NB+1)'(wy1_4_reg)))
        else $error("weights do not sum to cell steps");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg && op7_reg == OP_QUERY |-> DENW'(num7_reg >> ALPHA_W) < den7_reg)
        else $error("quotient exceeds sample range");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.alpha_out == '0 || out_ch.alpha_out >= 8'd127)
        else $error("alpha remap out of range");

endmodule

// File: dv/distance_field_bilinear_upscale_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_field_bilinear_upscale_tb
// Fills the whole sample grid, then runs directed and random load/query
// traffic over several output sizes. A scoreboard keeps its own copy of the
// grid and sizes and predicts each alpha beat, which is checked in order.
// ----------------------------------------------------------------------------
module distance_field_bilinear_upscale_tb;

    import dfbu_pkg::*;

    localparam int unsigned EDGE      = GRID_EDGE_DEF;
    localparam int unsigned SETTLE    = 12;     // pipeline depth plus margin
    localparam int unsigned IDLE_MAX  = 5000;   // cycles with no beat at all
    localparam int unsigned RAND_ITEMS = 300;

    typedef struct packed {
        logic                op;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [SAMPLE_W-1:0] val;
        logic [PIX_W-1:0]    px;
        logic [PIX_W-1:0]    py;
    } beat_t;

    // ------------------------------------------------------------------------
    // Alpha scoreboard: grid copy, sizes, and queue of expected alpha values
    // ------------------------------------------------------------------------
    class alpha_scoreboard;
        logic [SAMPLE_W-1:0] grid [EDGE*EDGE];
        int unsigned         width;
        int unsigned         height;
        logic [ALPHA_W-1:0]  alpha_q [$];
        int unsigned         errors;

        function new();
            width  = SIZE_RESET;
            height = SIZE_RESET;
            errors = 0;
            foreach (grid[i]) grid[i] = '0;
        endfunction

        // cell indexes and weights along one axis
        function void axis(input int unsigned size, input int unsigned p,
                           output int unsigned i0, output int unsigned i1,
                           output int unsigned w0, output int unsigned w1,
                           output int unsigned n);
            int unsigned h, a, b, pos0, pos1;
            n = size / EDGE;
            if (n == 0) n = 1;
            h = n >> 1;
            if (p < h) begin
                a = 0; b = 0;
            end
            else if (p >= size - h) begin
                a = EDGE - 1; b = EDGE - 1;
            end
            else begin
                a = (p - h) / n;
                b = a + 1;
            end
            if (a > EDGE - 1) a = EDGE - 1;
            if (b > EDGE - 1) b = EDGE - 1;
            pos0 = h + n * a;
            pos1 = pos0 + n;
            if (p < pos0) begin
                w0 = n; w1 = 0;
            end
            else if (p > pos1) begin
                w0 = 0; w1 = n;
            end
            else begin
                w1 = p - pos0;
                w0 = n - w1;
            end
            i0 = a;
            i1 = b;
        endfunction

        function longint unsigned at(int unsigned c, int unsigned r);
            return grid[r * EDGE + c];
        endfunction

        function logic [ALPHA_W-1:0] predict_alpha(int unsigned px, int unsigned py);
            int unsigned l, r, wx0, wx1, lx, t, b, wy0, wy1, ly;
            longint unsigned topv, botv, num, a;
            if (width == EDGE && height == EDGE) begin
                if (px > EDGE - 1) px = EDGE - 1;
                if (py > EDGE - 1) py = EDGE - 1;
                a = at(px, py);
            end
            else begin
                axis(width, px, l, r, wx0, wx1, lx);
                axis(height, py, t, b, wy0, wy1, ly);
                topv = at(l, t) * wx0 + at(r, t) * wx1;
                botv = at(l, b) * wx0 + at(r, b) * wx1;
                num  = topv * wy0 + botv * wy1;
                a    = num / (lx * ly);
            end
            if (a >= ALPHA_THRESH) a = (REMAP_BIAS + 2 * a) / 4;
            else                   a = 0;
            return a[ALPHA_W-1:0];
        endfunction

        function void note_input(beat_t bt);
            if (bt.op == OP_LOAD)
                grid[(EDGE - 1 - bt.row) * EDGE + bt.col] = bt.val;
            else
                alpha_q.push_back(predict_alpha(bt.px, bt.py));
        endfunction

        function void check_result(logic [ALPHA_W-1:0] got);
            logic [ALPHA_W-1:0] want;
            if (alpha_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected alpha beat %0d", got);
                return;
            end
            want = alpha_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("alpha mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    dfbu_in_if  in_ch ();
    dfbu_out_if out_ch ();

    distance_field_bilinear_upscale dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    alpha_scoreboard sb = new();

    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned rdy_mode = 0;
    int unsigned rdy_span = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitors: both channels sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input('{in_ch.operation, in_ch.grid_col, in_ch.grid_row,
                            in_ch.sample_value, in_ch.pixel_x, in_ch.pixel_y});
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.alpha_out);
    end

    // Receiver stall pattern: windows of always-ready, random, mostly stalled
    always @(posedge clk)
    begin
        if (rdy_span == 0)
        begin
            rdy_mode = $urandom_range(0, 2);
            rdy_span = $urandom_range(8, 64);
        end
        rdy_span--;
        case (rdy_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= $urandom_range(0, 1);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One input beat, with bursts and gaps on the sender side
    task automatic send(beat_t bt);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= bt.op;
        in_ch.grid_col     <= bt.col;
        in_ch.grid_row     <= bt.row;
        in_ch.sample_value <= bt.val;
        in_ch.pixel_x      <= bt.px;
        in_ch.pixel_y      <= bt.py;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic load(int unsigned c, int unsigned r, int unsigned v);
        beat_t bt;
        bt = '{OP_LOAD, c[COORD_W-1:0], r[COORD_W-1:0], v[SAMPLE_W-1:0],
               PIX_W'($urandom), PIX_W'($urandom)};
        send(bt);
    endtask

    task automatic query(int unsigned x, int unsigned y);
        beat_t bt;
        bt = '{OP_QUERY, COORD_W'($urandom), COORD_W'($urandom),
               SAMPLE_W'($urandom), x[PIX_W-1:0], y[PIX_W-1:0]};
        send(bt);
    endtask

    // Stop sending, wait for every alpha beat, let the pipeline empty
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.alpha_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Both size registers, written back to back while idle
    task automatic set_size(int unsigned w, int unsigned h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w[SIZE_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h[SIZE_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.width  = w;
        sb.height = h;
    endtask

    // Random phase: mostly queries over the image, some past it, some reloads
    task automatic random_phase(int unsigned w, int unsigned h, int unsigned count);
        int unsigned x, y;
        set_size(w, h);
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                load($urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
                     $urandom_range(0, 255));
            else
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                else
                begin
                    x = $urandom_range(0, (w > 4096 ? 4096 : w) - 1);
                    y = $urandom_range(0, (h > 4096 ? 4096 : h) - 1);
                end
                query(x, y);
            end
        end
        drain();
    endtask

    // Stimulus
    initial
    begin
        int unsigned done;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_WIDTH;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_LOAD;
        in_ch.grid_col     <= '0;
        in_ch.grid_row     <= '0;
        in_ch.sample_value <= '0;
        in_ch.pixel_x      <= '0;
        in_ch.pixel_y      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole grid so no query reads an unwritten sample
        for (int r = 0; r < EDGE; r++)
            for (int c = 0; c < EDGE; c++)
                load(c, r, ($urandom_range(0, 1) ? $urandom_range(100, 255)
                                                 : $urandom_range(0, 255)));

        // direct lookup at reset size: corners, past-grid saturation, threshold
        load(0, 31, 8'd255);
        load(31, 0, 8'd0);
        load(5, 31 - 3, 8'd127);
        load(6, 31 - 3, 8'd128);
        query(0, 0);
        query(31, 31);
        query(4095, 4095);
        query(5, 3);
        query(6, 3);
        query(40, 0);
        drain();

        // size 4096: half step, last cell and pixels past the last sample
        set_size(4096, 4096);
        query(0, 0);
        query(63, 64);
        query(64, 127);
        query(4031, 4032);
        query(4095, 4095);
        query(2047, 100);
        drain();

        // one axis at grid size, the other not: no longer a direct lookup
        set_size(33, 32);
        query(32, 31);
        query(0, 4095);
        query(16, 16);
        drain();

        // random phases over several sizes, extremes first
        random_phase(32, 32, 30);
        random_phase(4096, 32, 30);
        random_phase(32, 4096, 30);
        random_phase(4096, 4096, 30);
        done = 120;
        while (done < RAND_ITEMS)
        begin
            random_phase($urandom_range(32, 4096), $urandom_range(32, 300), 30);
            done += 30;
        end

        if (sb.errors == 0 && sb.alpha_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
